### sv/kac_pkg.sv
`timescale 1ns / 1ps

package kac_pkg;

    localparam int SYM_N = 29;
    localparam int SYM_W = 5;
    localparam int CH_W  = 8;
    localparam int FN_W  = 3;

    localparam logic [FN_W-1:0] FN_CLEAR  = 3'd0;
    localparam logic [FN_W-1:0] FN_KEY    = 3'd1;
    localparam logic [FN_W-1:0] FN_END    = 3'd2;
    localparam logic [FN_W-1:0] FN_TEXT   = 3'd3;
    localparam logic [FN_W-1:0] FN_NEWMSG = 3'd4;

    localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(SYM_N - 1);

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] code;
    } t_sym;

    function automatic t_sym sym_decode(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] c;
        t_sym            s;
        c = ch;
        s.ok = 1'b0;
        s.code = '0;
        if (c >= 8'h61 && c <= 8'h7a) begin
            c = c - 8'd32;
        end
        if (c >= 8'h41 && c <= 8'h5a) begin
            s.ok = 1'b1;
            s.code = SYM_W'(c - 8'h41);
        end else if (c == 8'h2c) begin
            s.ok = 1'b1;
            s.code = 5'd26;
        end else if (c == 8'h2e) begin
            s.ok = 1'b1;
            s.code = 5'd27;
        end else if (c == 8'h20) begin
            s.ok = 1'b1;
            s.code = 5'd28;
        end
        return s;
    endfunction

    function automatic logic [CH_W-1:0] sym_ascii(input logic [SYM_W-1:0] code);
        logic [CH_W-1:0] a;
        case (code)
            5'd26:   a = 8'h2c;
            5'd27:   a = 8'h2e;
            5'd28:   a = 8'h20;
            5'd29, 5'd30, 5'd31: a = 8'h00;
            default: a = 8'h41 + CH_W'(code);
        endcase
        return a;
    endfunction

endpackage

### sv/kac_if.sv
`timescale 1ns / 1ps

interface kac_in_if import kac_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [FN_W-1:0] func;
    logic [CH_W-1:0] char_in;

    modport source (output valid, output func, output char_in, input ready);
    modport sink (input valid, input func, input char_in, output ready);
endinterface

interface kac_out_if import kac_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] char_out;
    logic            is_key;
    logic            last;
    logic            no_key;

    modport source (output valid, output char_out, output is_key, output last,
                     output no_key, input ready);
    modport sink (input valid, input char_out, input is_key, input last,
                  input no_key, output ready);
endinterface

### sv/kac_ram.sv
`timescale 1ns / 1ps

module kac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/keyword_alphabet_running_cipher.sv
`timescale 1ns / 1ps
// Keyword mixed-alphabet running substitution cipher.
// Input channel i_in carries a function code and a character byte; output
// channel o_out carries result bytes with is_key, last and no_key flags.
// Both use valid/ready; a transfer happens when both are high.
// Clear key, key characters and new message give no result.
// A plaintext character gives one result (none once the key is ready if it has
// no symbol) via the table read, then the output register; a stream of plaintext
// is taken one character per cycle while the receiver keeps ready high.
// Key end first steps through all 29 symbols and appends each one missing from
// the key table, then lists the 29-symbol key, one table read per cycle while
// the output is not stalled; no input is taken in that time.
// Plaintext before key end gives one result with no_key set and char_out 0.
// When the receiver stalls, the output register holds its transfer and the
// pending table read holds its data; input is taken again once the pending
// result can move into the output register.
// Reset clears the used-symbol map, key length, key-ready flag, running index
// and all handshake state; the key table itself needs no reset.
module keyword_alphabet_running_cipher import kac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kac_in_if.sink    i_in,
    kac_out_if.source o_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_LIST = 2'd2;

    logic [1:0]       r_state,   n_state;
    logic [SYM_N-1:0] r_seen,    n_seen;
    logic [SYM_W-1:0] r_len,     n_len;
    logic             r_kready,  n_kready;
    logic [SYM_W-1:0] r_idx,     n_idx;
    logic [SYM_W-1:0] r_cnt,     n_cnt;
    logic             r_pend,    n_pend;
    logic             r_p_isk,   n_p_isk;
    logic             r_p_last,  n_p_last;
    logic             r_p_nk,    n_p_nk;
    logic             r_ov;
    logic [CH_W-1:0]  r_char;
    logic             r_isk;
    logic             r_last;
    logic             r_nk;

    logic             can_load;
    logic             accept;
    logic             we;
    logic [SYM_W-1:0] waddr;
    logic [SYM_W-1:0] wdata;
    logic             issue;
    logic [SYM_W-1:0] raddr;
    logic [SYM_W-1:0] rdata;
    logic [SYM_W:0]   sum;
    t_sym             sym;

    assign can_load   = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && (!r_pend || can_load);
    assign accept     = i_in.valid && i_in.ready;
    assign sym        = sym_decode(i_in.char_in);

    always_comb begin
        sum = {1'b0, r_idx} + {1'b0, sym.code} + 6'd1;
        if (sum >= 6'(SYM_N)) begin
            sum = sum - 6'(SYM_N);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_seen   = r_seen;
        n_len    = r_len;
        n_kready = r_kready;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_p_isk  = r_p_isk;
        n_p_last = r_p_last;
        n_p_nk   = r_p_nk;
        we       = 1'b0;
        waddr    = r_len;
        wdata    = sym.code;
        issue    = 1'b0;
        raddr    = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in.func)
                        FN_CLEAR: begin
                            n_seen   = '0;
                            n_len    = '0;
                            n_kready = 1'b0;
                            n_idx    = '0;
                        end
                        FN_KEY: begin
                            if (!r_kready && sym.ok && !r_seen[sym.code]
                                && r_len < SYM_W'(SYM_N)) begin
                                we               = 1'b1;
                                n_seen[sym.code] = 1'b1;
                                n_len            = r_len + 5'd1;
                            end
                        end
                        FN_END: begin
                            n_state  = ST_FILL;
                            n_cnt    = '0;
                            n_kready = 1'b1;
                            n_idx    = '0;
                        end
                        FN_TEXT: begin
                            if (!r_kready) begin
                                issue    = 1'b1;
                                n_p_isk  = 1'b0;
                                n_p_last = 1'b1;
                                n_p_nk   = 1'b1;
                            end else if (sym.ok) begin
                                issue    = 1'b1;
                                raddr    = sum[SYM_W-1:0];
                                n_idx    = sum[SYM_W-1:0];
                                n_p_isk  = 1'b0;
                                n_p_last = 1'b1;
                                n_p_nk   = 1'b0;
                            end
                        end
                        FN_NEWMSG: begin
                            n_idx = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                wdata = r_cnt;
                if (!r_seen[r_cnt] && r_len < SYM_W'(SYM_N)) begin
                    we            = 1'b1;
                    n_seen[r_cnt] = 1'b1;
                    n_len         = r_len + 5'd1;
                end
                if (r_cnt == SYM_LAST) begin
                    n_state = ST_LIST;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_LIST: begin
                if (!r_pend || can_load) begin
                    issue    = 1'b1;
                    n_p_isk  = 1'b1;
                    n_p_last = (r_cnt == SYM_LAST);
                    n_p_nk   = 1'b0;
                    if (r_cnt == SYM_LAST) begin
                        n_state = ST_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (issue) begin
            n_pend = 1'b1;
        end else if (can_load) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end
    end

    kac_ram #(
        .WIDTH(SYM_W),
        .DEPTH(SYM_N)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (issue),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seen   <= '0;
            r_len    <= '0;
            r_kready <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seen   <= n_seen;
            r_len    <= n_len;
            r_kready <= n_kready;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_pend   <= n_pend;
            if (r_pend && can_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_isk  <= n_p_isk;
        r_p_last <= n_p_last;
        r_p_nk   <= n_p_nk;
        if (r_pend && can_load) begin
            r_char <= r_p_nk ? '0 : sym_ascii(rdata);
            r_isk  <= r_p_isk;
            r_last <= r_p_last;
            r_nk   <= r_p_nk;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.char_out = r_char;
    assign o_out.is_key   = r_isk;
    assign o_out.last     = r_last;
    assign o_out.no_key   = r_nk;

endmodule

### tb/sv/kac_cipher_checker.sv
`timescale 1ns / 1ps

module kac_cipher_checker import kac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    kac_in_if    i_in_mon,
    kac_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_outstanding
);

    typedef struct packed {
        logic [CH_W-1:0] char_out;
        logic            is_key;
        logic            last;
        logic            no_key;
    } t_cipher_result;

    t_cipher_result   pending_results[$];
    logic [SYM_W-1:0] key_tab[SYM_N];
    logic [SYM_N-1:0] used_syms;
    int               key_len;
    logic             key_done;
    int               run_idx;
    int               fails;

    function automatic int symbol_of(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] up;
        up = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'h20 : ch;
        if (up >= 8'h41 && up <= 8'h5a) begin
            return int'(up) - 'h41;
        end
        if (up == 8'h2c) begin
            return 26;
        end
        if (up == 8'h2e) begin
            return 27;
        end
        if (up == 8'h20) begin
            return 28;
        end
        return -1;
    endfunction

    function automatic logic [CH_W-1:0] symbol_char(input int code);
        if (code < 26) begin
            return 8'h41 + CH_W'(code);
        end
        if (code == 26) begin
            return 8'h2c;
        end
        if (code == 27) begin
            return 8'h2e;
        end
        return 8'h20;
    endfunction

    task automatic append_symbol(input int code);
        if (key_len < SYM_N && !used_syms[code]) begin
            used_syms[code] = 1'b1;
            key_tab[key_len] = SYM_W'(code);
            key_len++;
        end
    endtask

    task automatic predict_cipher_output(input logic [FN_W-1:0] f, input logic [CH_W-1:0] ch);
        int code;
        code = symbol_of(ch);
        case (f)
            FN_CLEAR: begin
                used_syms = '0;
                key_len = 0;
                key_done = 1'b0;
                run_idx = 0;
            end
            FN_KEY: begin
                if (!key_done && code >= 0) begin
                    append_symbol(code);
                end
            end
            FN_END: begin
                for (int s = 0; s < SYM_N; s++) begin
                    append_symbol(s);
                end
                key_done = 1'b1;
                run_idx = 0;
                for (int k = 0; k < SYM_N; k++) begin
                    pending_results.push_back('{symbol_char(int'(key_tab[k])), 1'b1,
                                                k == SYM_N - 1, 1'b0});
                end
            end
            FN_TEXT: begin
                if (!key_done) begin
                    pending_results.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
                end else if (code >= 0) begin
                    run_idx = (run_idx + code + 1) % SYM_N;
                    pending_results.push_back('{symbol_char(int'(key_tab[run_idx])), 1'b0,
                                                1'b1, 1'b0});
                end
            end
            FN_NEWMSG: begin
                run_idx = 0;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_cipher_result got;
        t_cipher_result want;
        if (!i_rst_n) begin
            pending_results.delete();
            used_syms = '0;
            key_len = 0;
            key_done = 1'b0;
            run_idx = 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                predict_cipher_output(i_in_mon.func, i_in_mon.char_in);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{i_out_mon.char_out, i_out_mon.is_key, i_out_mon.last,
                        i_out_mon.no_key};
                if (pending_results.size() == 0) begin
                    $error("unexpected result transfer: char_out %h is_key %b last %b no_key %b",
                           got.char_out, got.is_key, got.last, got.no_key);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.char_out !== want.char_out) begin
                        $error("char_out: expected %h, got %h", want.char_out, got.char_out);
                        fails++;
                    end
                    if (got.is_key !== want.is_key) begin
                        $error("is_key: expected %b, got %b", want.is_key, got.is_key);
                        fails++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, got.last);
                        fails++;
                    end
                    if (got.no_key !== want.no_key) begin
                        $error("no_key: expected %b, got %b", want.no_key, got.no_key);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_outstanding <= pending_results.size();
    end

endmodule

### tb/sv/tb_keyword_alphabet_running_cipher.sv
`timescale 1ns / 1ps

module tb_keyword_alphabet_running_cipher;

    import kac_pkg::*;

    localparam logic [FN_W-1:0] FN_RSVD5 = 3'd5;
    localparam logic [FN_W-1:0] FN_RSVD6 = 3'd6;
    localparam logic [FN_W-1:0] FN_RSVD7 = 3'd7;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_TARGET  = 500;
    localparam int DRAIN_CYCLES = 20;

    logic  i_clk;
    logic  i_rst_n;
    int    fail_count;
    int    outstanding;
    int    items_sent;
    bit    no_idle;
    bit    hold_req;
    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ,. ";

    kac_in_if  in_if();
    kac_out_if out_if();

    keyword_alphabet_running_cipher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    kac_cipher_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_if),
        .i_out_mon     (out_if),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [CH_W-1:0] symbol_char_any_case(input int code);
        logic [CH_W-1:0] c;
        c = alphabet[code];
        if (code < 26 && $urandom_range(1) == 1) begin
            c = c | 8'h20;
        end
        return c;
    endfunction

    task automatic send_item(input logic [FN_W-1:0] f, input logic [CH_W-1:0] c);
        while (!no_idle && $urandom_range(99) < 12) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.func <= f;
        in_if.char_in <= c;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic run_session(input bit full_key);
        logic [SYM_W-1:0] order[SYM_N];
        logic [SYM_W-1:0] tmp;
        int               j;
        int               r;
        send_item(FN_CLEAR, CH_W'($urandom_range(255)));
        if (full_key) begin
            for (int k = 0; k < SYM_N; k++) begin
                order[k] = SYM_W'(k);
            end
            for (int k = SYM_N - 1; k > 0; k--) begin
                j = $urandom_range(k);
                tmp = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            for (int k = 0; k < SYM_N; k++) begin
                send_item(FN_KEY, symbol_char_any_case(int'(order[k])));
            end
        end else begin
            repeat ($urandom_range(14)) begin
                if ($urandom_range(99) < 85) begin
                    send_item(FN_KEY, symbol_char_any_case($urandom_range(SYM_N - 1)));
                end else begin
                    send_item(FN_KEY, CH_W'($urandom_range(255)));
                end
            end
        end
        send_item(FN_END, CH_W'($urandom_range(255)));
        repeat ($urandom_range(40, 4)) begin
            r = $urandom_range(99);
            if (r < 88) begin
                send_item(FN_TEXT, symbol_char_any_case($urandom_range(SYM_N - 1)));
            end else if (r < 94) begin
                send_item(FN_NEWMSG, CH_W'($urandom_range(255)));
            end else begin
                send_item(FN_TEXT, CH_W'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= no_idle || ($urandom_range(99) >= 12);
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("keyword_alphabet_running_cipher verification failed");
        $finish;
    end

    initial begin
        int session;
        in_if.valid <= 1'b0;
        in_if.func <= FN_CLEAR;
        in_if.char_in <= '0;
        i_rst_n <= 1'b0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        items_sent = 0;
        session = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(FN_TEXT, "A");
        send_item(FN_TEXT, 8'h00);
        send_item(FN_KEY, "k");
        send_item(FN_KEY, "E");
        send_item(FN_KEY, "e");
        send_item(FN_KEY, "1");
        send_item(FN_KEY, ",");
        send_item(FN_KEY, 8'hff);
        send_item(FN_KEY, "z");
        send_item(FN_KEY, " ");
        send_item(FN_KEY, ".");
        send_item(FN_RSVD5, "Q");
        send_item(FN_RSVD6, 8'h7f);
        send_item(FN_RSVD7, 8'h80);
        send_item(FN_END, 8'h00);
        send_item(FN_KEY, "Q");
        send_item(FN_TEXT, "a");
        send_item(FN_TEXT, "Z");
        send_item(FN_TEXT, " ");
        send_item(FN_TEXT, ",");
        send_item(FN_TEXT, ".");
        send_item(FN_TEXT, 8'h80);
        send_item(FN_NEWMSG, 8'hff);
        send_item(FN_TEXT, "y");
        send_item(FN_END, 8'h55);
        send_item(FN_CLEAR, 8'haa);
        send_item(FN_TEXT, "B");

        while (items_sent < ITEM_TARGET) begin
            no_idle = (session == 2 || session == 3);
            if (session == 5) begin
                hold_req = 1'b1;
            end
            if (session <= 5 || $urandom_range(9) < 8) begin
                run_session(session == 0);
            end else begin
                repeat (6) begin
                    send_item(FN_W'($urandom_range(7)), CH_W'($urandom_range(255)));
                end
            end
            if (session == 6) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
                while (outstanding != 0) begin
                    @(posedge i_clk);
                end
            end
            session++;
        end

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("keyword_alphabet_running_cipher verification clean");
        end else begin
            $display("keyword_alphabet_running_cipher verification failed");
        end
        $finish;
    end

endmodule

### keyword_alphabet_running_cipher.f
sv/kac_pkg.sv
sv/kac_if.sv
sv/kac_ram.sv
sv/keyword_alphabet_running_cipher.sv
tb/sv/kac_cipher_checker.sv
tb/sv/tb_keyword_alphabet_running_cipher.sv
